[rtl/core/cfd_pkg.sv]
package cfd_pkg;

  localparam int unsigned CountWidth = 9;

  localparam logic [CountWidth-1:0] HdrBytes   = 9'd5;
  localparam logic [CountWidth-1:0] HeaderLast = 9'd4;
  localparam logic [CountWidth-1:0] CrcBytes   = 9'd2;
  localparam logic [CountWidth-1:0] MinFrame   = 9'd7;
  localparam logic [CountWidth-1:0] CountMax   = 9'd511;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_SIZE_ERR  = 2'd2,
    STATUS_CRC_ERR   = 2'd3
  } status_e;

  typedef struct packed {
    logic       is_payload;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_end;
    status_e    status_code;
    logic [7:0] frame_header;
    logic [7:0] frame_sequence;
    logic [7:0] frame_device;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
  } result_t;

endpackage

[rtl/core/cfd_if.sv]
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface cfd_out_if;
  logic       valid;
  logic       ready;
  logic       is_payload;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_end;
  logic [1:0] status_code;
  logic [7:0] frame_header;
  logic [7:0] frame_sequence;
  logic [7:0] frame_device;
  logic [7:0] frame_command;
  logic [7:0] payload_length;

  modport source (
    output valid, output is_payload, output payload_byte, output payload_index,
    output frame_end, output status_code, output frame_header, output frame_sequence,
    output frame_device, output frame_command, output payload_length, input ready
  );
  modport sink (
    input valid, input is_payload, input payload_byte, input payload_index,
    input frame_end, input status_code, input frame_header, input frame_sequence,
    input frame_device, input frame_command, input payload_length, output ready
  );
endinterface

[rtl/core/cfd_crc_step.sv]
module cfd_crc_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  logic [15:0] acc;

  // CRC-16/MODBUS, reflected, one byte per call
  always_comb begin
    acc = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ cfd_pkg::CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

[rtl/core/crc_frame_deframer_unit.sv]
// Receive-side frame checker for length-prefixed frames protected by
// CRC-16/MODBUS (low CRC byte first).
// Input channel in_i: one received byte per request, end_of_frame set on the
// last byte of the frame. Output channel out_o: one result per input byte.
// Payload bytes come out with is_payload set and their index; the result of
// the last byte carries frame_end, the status and the header fields. The
// sink should discard the payload of a frame whose status is not ok.
// The result is registered and is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless out_o.ready is low; the byte-wide CRC update and the byte
// counter sit between the frame state registers and the result register.
// Receiver stall: the single result register holds its value; in_i.ready
// stays high while the held result is being taken in the same cycle, so the
// stream keeps full rate unless out_o.ready is low.
// Reset: asynchronous, clears the frame state (CRC to 0xFFFF) and the
// result valid flag. The frame state also clears itself after each last
// byte, so the next byte starts a new frame.
module crc_frame_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfd_in_if.sink     in_i,
  cfd_out_if.source  out_o
);

  logic [cfd_pkg::CountWidth-1:0] byte_count_q, byte_count_d;
  logic [15:0]                    running_crc_q, running_crc_d;
  logic [7:0]                     declared_length_q, declared_length_d;
  logic [31:0]                    header_fields_q, header_fields_d;
  logic [15:0]                    received_crc_q, received_crc_d;

  logic                           out_valid_q;
  cfd_pkg::result_t               result_q, result_d;

  logic                           in_fire;
  logic [7:0]                     len_eff;
  logic [cfd_pkg::CountWidth-1:0] crc_limit;
  logic [cfd_pkg::CountWidth-1:0] total;
  logic                           in_crc_span;
  logic                           in_payload;
  logic [15:0]                    crc_step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  cfd_crc_step u_crc_step (
    .crc_i  (running_crc_q),
    .data_i (in_i.rx_byte),
    .crc_o  (crc_step)
  );

  always_comb begin
    len_eff     = (byte_count_q == cfd_pkg::HeaderLast) ? in_i.rx_byte : declared_length_q;
    crc_limit   = cfd_pkg::HdrBytes + {1'b0, len_eff};
    in_crc_span = byte_count_q < crc_limit;
    in_payload  = in_crc_span && (byte_count_q >= cfd_pkg::HdrBytes);
    total       = (byte_count_q != cfd_pkg::CountMax) ? byte_count_q + 9'd1 : byte_count_q;

    header_fields_d = header_fields_q;
    if (byte_count_q < cfd_pkg::HeaderLast) begin
      header_fields_d = header_fields_q
                      | ({24'h000000, in_i.rx_byte} << {byte_count_q[1:0], 3'b000});
    end
    declared_length_d = len_eff;
    running_crc_d     = in_crc_span ? crc_step : running_crc_q;

    received_crc_d = received_crc_q;
    if (!in_crc_span && (byte_count_q == crc_limit)) begin
      received_crc_d = {received_crc_q[15:8], in_i.rx_byte};
    end else if (byte_count_q == crc_limit + 9'd1) begin
      received_crc_d = {in_i.rx_byte, received_crc_q[7:0]};
    end
    byte_count_d = total;

    result_d               = '0;
    result_d.is_payload    = in_payload;
    result_d.frame_end     = in_i.end_of_frame;
    result_d.status_code   = cfd_pkg::STATUS_OK;
    if (in_payload) begin
      result_d.payload_byte  = in_i.rx_byte;
      result_d.payload_index = byte_count_q[7:0] - cfd_pkg::HdrBytes[7:0];
    end
    if (in_i.end_of_frame) begin
      if (total < cfd_pkg::MinFrame) begin
        result_d.status_code = cfd_pkg::STATUS_TOO_SHORT;
      end else if (total != crc_limit + cfd_pkg::CrcBytes) begin
        result_d.status_code = cfd_pkg::STATUS_SIZE_ERR;
      end else if (running_crc_d != received_crc_d) begin
        result_d.status_code = cfd_pkg::STATUS_CRC_ERR;
      end
      result_d.frame_header   = header_fields_d[7:0];
      result_d.frame_sequence = header_fields_d[15:8];
      result_d.frame_device   = header_fields_d[23:16];
      result_d.frame_command  = header_fields_d[31:24];
      result_d.payload_length = declared_length_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q      <= '0;
      running_crc_q     <= cfd_pkg::CrcInit;
      declared_length_q <= '0;
      header_fields_q   <= '0;
      received_crc_q    <= '0;
    end else if (in_fire) begin
      if (in_i.end_of_frame) begin
        byte_count_q      <= '0;
        running_crc_q     <= cfd_pkg::CrcInit;
        declared_length_q <= '0;
        header_fields_q   <= '0;
        received_crc_q    <= '0;
      end else begin
        byte_count_q      <= byte_count_d;
        running_crc_q     <= running_crc_d;
        declared_length_q <= declared_length_d;
        header_fields_q   <= header_fields_d;
        received_crc_q    <= received_crc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.is_payload     = result_q.is_payload;
  assign out_o.payload_byte   = result_q.payload_byte;
  assign out_o.payload_index  = result_q.payload_index;
  assign out_o.frame_end      = result_q.frame_end;
  assign out_o.status_code    = result_q.status_code;
  assign out_o.frame_header   = result_q.frame_header;
  assign out_o.frame_sequence = result_q.frame_sequence;
  assign out_o.frame_device   = result_q.frame_device;
  assign out_o.frame_command  = result_q.frame_command;
  assign out_o.payload_length = result_q.payload_length;

endmodule

[rtl/core/cfd_checker.sv]
module cfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       is_payload_i,
  input logic [7:0] payload_byte_i,
  input logic       frame_end_i,
  input logic [1:0] status_code_i,
  input logic [7:0] frame_header_i
);

  // held result must stay until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a result only appears after an accepted request
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without request");

  // empty output stage never blocks the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_end_i |-> status_code_i == cfd_pkg::STATUS_OK
                                    && frame_header_i == 8'h00)
    else $error("status outside frame end");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_payload_i |-> payload_byte_i == 8'h00)
    else $error("payload byte outside payload span");

endmodule

bind crc_frame_deframer_unit cfd_checker u_cfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .is_payload_i   (out_o.is_payload),
  .payload_byte_i (out_o.payload_byte),
  .frame_end_i    (out_o.frame_end),
  .status_code_i  (out_o.status_code),
  .frame_header_i (out_o.frame_header)
);
